FILE: rtl/core/lipu_pkg.sv
// Package for the linear interpolation upsampler.
// Holds widths, limits, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package lipu_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_MULT       = 64;
    localparam int MULT_BITS      = 7;
    localparam int IDX_BITS       = 32;
    localparam int DIFF_BITS      = SAMPLE_BITS + 1;
    localparam int DIV_STEPS      = DIFF_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
    localparam int OUT_TDATA_BITS = SAMPLE_BITS + IDX_BITS;

    localparam logic [MULT_BITS-1:0] MULT_RESET = MULT_BITS'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic fix;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic interp;
        logic div_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/lipu_ctrl.sv
// Controller state machine of the linear interpolation upsampler.
// Sequences accept, serial divide, quotient fix-up and result emission.
// Depends on lipu_pkg.
`default_nettype none

module lipu_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  lipu_pkg::t_status i_status,
    output lipu_pkg::t_cmd   o_cmd
);
    import lipu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.interp) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                // advance only when the output register can take a beat
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/lipu_dpath.sv
// Datapath of the linear interpolation upsampler: held sample, index, config,
// restoring divider for diff / M, incremental quotient stepper and output register.
// Depends on lipu_pkg.
`default_nettype none

module lipu_dpath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [lipu_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  wire                                  i_start_new,
    input  wire                                  i_cfg_we,
    input  wire  [lipu_pkg::MULT_BITS-1:0]       i_cfg_wdata,
    input  wire                                  i_m_tready,
    input  lipu_pkg::t_cmd                       i_cmd,
    output lipu_pkg::t_status                    o_status,
    output logic                                 o_m_tvalid,
    output logic [lipu_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    output logic                                 o_m_tlast
);
    import lipu_pkg::*;

    logic [MULT_BITS-1:0]    r_mult;
    logic [SAMPLE_BITS-1:0]  r_held;
    logic                    r_have;
    logic [IDX_BITS-1:0]     r_count;

    logic [SAMPLE_BITS-1:0]  r_base;
    logic                    r_neg;
    logic [MULT_BITS-1:0]    r_m;
    logic [DIFF_BITS-1:0]    r_work;
    logic [MULT_BITS-1:0]    r_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt;

    logic [DIFF_BITS-1:0]    r_qd;
    logic [MULT_BITS-1:0]    r_rd;
    logic [DIFF_BITS-1:0]    r_q;
    logic [MULT_BITS-1:0]    r_r;
    logic [MULT_BITS-1:0]    r_k;

    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_value;
    logic [IDX_BITS-1:0]     r_out_index;
    logic                    r_out_last;

    logic [MULT_BITS-1:0]    m_eff;
    logic [DIFF_BITS-1:0]    diff;
    logic [DIFF_BITS-1:0]    mag;
    logic [MULT_BITS:0]      trial;
    logic                    qbit;
    logic [DIFF_BITS-1:0]    qd_fix;
    logic [MULT_BITS-1:0]    rd_fix;
    logic [MULT_BITS-1:0]    rsum;
    logic                    carry;

    always_comb begin
        if (r_mult == '0) begin
            m_eff = MULT_BITS'(1);
        end else if (r_mult > MULT_BITS'(MAX_MULT)) begin
            m_eff = MULT_BITS'(MAX_MULT);
        end else begin
            m_eff = r_mult;
        end
        diff = {i_sample[SAMPLE_BITS-1], i_sample} - {r_held[SAMPLE_BITS-1], r_held};
        mag  = diff[DIFF_BITS-1] ? (~diff + DIFF_BITS'(1)) : diff;

        // one restoring step: shift in next dividend bit, subtract M if it fits
        trial = {r_rem, r_work[DIFF_BITS-1]};
        qbit  = (trial >= {1'b0, r_m});

        // turn the magnitude quotient into floor division of the signed diff
        if (!r_neg) begin
            qd_fix = r_work;
            rd_fix = r_rem;
        end else if (r_rem == '0) begin
            qd_fix = ~r_work + DIFF_BITS'(1);
            rd_fix = '0;
        end else begin
            qd_fix = ~r_work;
            rd_fix = r_m - r_rem;
        end

        rsum  = r_r + r_rd;
        carry = (rsum >= r_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult  <= MULT_RESET;
            r_held  <= '0;
            r_have  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mult <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_held <= i_sample;
                r_have <= 1'b1;
                if (i_start_new) begin
                    r_count <= '0;
                end
            end else if (i_cmd.emit) begin
                r_count <= r_count + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base <= r_held;
            r_neg  <= diff[DIFF_BITS-1];
            r_work <= mag;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_m    <= m_eff;
        end
        if (i_cmd.div_step) begin
            r_rem  <= qbit ? MULT_BITS'(trial - {1'b0, r_m}) : MULT_BITS'(trial);
            r_work <= {r_work[DIFF_BITS-2:0], qbit};
            r_cnt  <= r_cnt + DIV_CNT_BITS'(1);
        end
        if (i_cmd.fix) begin
            r_qd <= qd_fix;
            r_rd <= rd_fix;
            r_q  <= '0;
            r_r  <= '0;
            r_k  <= '0;
        end
        if (i_cmd.emit) begin
            r_out_value <= r_base + r_q[SAMPLE_BITS-1:0];
            r_out_index <= r_count;
            r_out_last  <= (r_k == r_m - MULT_BITS'(1));
            r_k         <= r_k + MULT_BITS'(1);
            r_q         <= r_q + r_qd + DIFF_BITS'(carry);
            r_r         <= carry ? (rsum - r_m) : rsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.interp    = r_have && !i_start_new;
        o_status.div_last  = (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
        o_status.emit_last = (r_k == r_m - MULT_BITS'(1));
        o_status.out_free  = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_index, r_out_value};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/linear_interpolation_upsampler_top.sv
// A beat that only loads the held sample is taken in ST_IDLE and leaves the block ready;
// an interpolating beat gives its first result after 17 divider steps, a fix-up, a load.
// No new sample is taken until the emit loop has given all M results, M the clamped
// multiplier; the loop gives one result per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): no sample held, index 0, multiplier 4, output empty.
// Top level: joins lipu_ctrl and lipu_dpath; depends on lipu_pkg.
`default_nettype none

module linear_interpolation_upsampler_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [lipu_pkg::SAMPLE_BITS-1:0]     i_s_tdata,   // [15:0] sample
    input  wire                                  i_s_tuser,   // [0] start_new
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [lipu_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,   // [15:0] value, [47:16] out_index
    output logic                                 o_m_tlast,
    input  wire                                  i_cfg_we,
    input  wire  [lipu_pkg::MULT_BITS-1:0]       i_cfg_wdata
);
    import lipu_pkg::*;

    t_cmd    cmd;
    t_status status;

    lipu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lipu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_s_tdata),
        .i_start_new (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lipu_checker.sv
// Port-level checker for the linear interpolation upsampler, bound to the top level.
// Depends on lipu_pkg.
`default_nettype none

module lipu_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    input  wire                                  o_s_tready,
    input  wire  [lipu_pkg::SAMPLE_BITS-1:0]     i_s_tdata,
    input  wire                                  i_s_tuser,
    input  wire                                  o_m_tvalid,
    input  wire                                  i_m_tready,
    input  wire  [lipu_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    input  wire                                  o_m_tlast
);
    import lipu_pkg::*;

    logic                r_prev_seen;
    logic                r_prev_last;
    logic [IDX_BITS-1:0] r_prev_idx;
    logic                out_beat;

    assign out_beat = o_m_tvalid && i_m_tready;

    // track the last result beat taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_seen <= 1'b0;
            r_prev_last <= 1'b1;
            r_prev_idx  <= '0;
        end else if (out_beat) begin
            r_prev_seen <= 1'b1;
            r_prev_last <= o_m_tlast;
            r_prev_idx  <= o_m_tdata[OUT_TDATA_BITS-1:SAMPLE_BITS];
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=>
            i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser))
        else $error("input beat changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_run_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_prev_seen && !r_prev_last |->
            o_m_tdata[OUT_TDATA_BITS-1:SAMPLE_BITS] == r_prev_idx + IDX_BITS'(1))
        else $error("index not consecutive within a run");

    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready in the middle of a run");

endmodule

bind linear_interpolation_upsampler_top lipu_checker u_lipu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

`default_nettype wire

FILE: verif/tb_linear_interpolation_upsampler_top.sv
`timescale 1ns / 1ps
// Testbench for linear_interpolation_upsampler_top: random and directed sample streams,
// a segment interpolation predictor inside a small scoreboard class, random stalls.
// Depends on lipu_pkg and the upsampler RTL only.

typedef struct {
    logic signed [15:0] value;
    logic [31:0]        out_index;
    logic               last;
} t_interp_point;

module tb_linear_interpolation_upsampler_top;

    import lipu_pkg::*;

    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 40;

    class segment_scoreboard;
        logic [MULT_BITS-1:0] mult_reg;
        int                   held;
        bit                   have_held;
        logic [31:0]          next_index;
        t_interp_point        expected_points[$];
        int                   n_mismatch;

        function new();
            mult_reg   = MULT_RESET;
            held       = 0;
            have_held  = 0;
            next_index = 0;
            n_mismatch = 0;
        endfunction

        function void set_mult(logic [MULT_BITS-1:0] v);
            mult_reg = v;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // Round toward minus infinity.
        function int floor_div(int a, int b);
            int q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q = q - 1;
            return q;
        endfunction

        function void take_sample(logic signed [15:0] s, logic start);
            int            cur;
            int            m;
            int            diff;
            t_interp_point p;
            cur = s;
            if (start || !have_held) begin
                held      = cur;
                have_held = 1;
                if (start) next_index = 0;
                return;
            end
            m = mult_reg;
            if (m < 1) m = 1;
            if (m > MAX_MULT) m = MAX_MULT;
            diff = cur - held;
            for (int k = 0; k < m; k++) begin
                p.value     = 16'(held + floor_div(diff * k, m));
                p.out_index = next_index;
                p.last      = (k == m - 1);
                expected_points.push_back(p);
                next_index  = next_index + 1;
            end
            held = cur;
        endfunction

        function void check_point(logic [15:0] v, logic [31:0] idx, logic lst);
            t_interp_point e;
            if (expected_points.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: value %0d index %0d last %0b",
                             $signed(v), idx, lst);
                return;
            end
            e = expected_points.pop_front();
            if (e.value !== v || e.out_index !== idx || e.last !== lst) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: expected value %0d index %0d last %0b, got %0d %0d %0b",
                             e.value, e.out_index, e.last, $signed(v), idx, lst);
            end
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      s_tvalid    = 1'b0;
    logic                      s_tready;
    logic [SAMPLE_BITS-1:0]    s_tdata     = '0;
    logic                      s_tuser     = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready    = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;
    logic                      cfg_we      = 1'b0;
    logic [MULT_BITS-1:0]      cfg_wdata   = '0;

    segment_scoreboard sb;
    bit                quiet    = 0;
    bit                hold_req = 0;
    int                cycles   = 0;

    linear_interpolation_upsampler_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL linear_interpolation_upsampler_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_point(m_tdata[15:0], m_tdata[47:16], m_tlast);
    end

    // Output back-pressure: random stall bursts, one long hold-off on request.
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send_sample(logic signed [15:0] s, logic start);
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= start;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.take_sample(s, start);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Wait for all results, then give a held-only beat time to finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mult(logic [MULT_BITS-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_mult(v);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample(logic signed [15:0] prev);
        case ($urandom_range(0, 5))
            0:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            1:       return 16'($urandom_range(0, 1)) - 16'sd1;
            2, 3:    return prev + 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom());
        endcase
    endfunction

    logic [MULT_BITS-1:0] mult_plan[10] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65,
                                            7'd7, 7'd2, 7'd33, 7'd5, 7'd3};

    initial begin
        logic signed [15:0] s;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed run at the reset multiplier of 4.
        send_sample(16'sh7fff, 1'b0);   // nothing held yet: hold only
        send_sample(16'sh8000, 1'b0);   // full negative swing
        send_sample(16'sh7fff, 1'b0);   // full positive swing
        send_sample(16'sh7fff, 1'b0);   // flat segment
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd100, 1'b1);    // new sequence: index back to 0
        send_sample(-16'sd5, 1'b0);     // negative slope, floor rounding
        send_sample(-16'sd7, 1'b1);
        send_sample(16'sd3, 1'b1);      // back-to-back new sequences
        send_sample(16'sd10, 1'b0);
        send_sample(16'sh8000, 1'b0);
        s = 16'sh8000;

        for (int ph = 0; ph < 10; ph++) begin
            write_mult((ph == 9) ? 7'($urandom_range(0, 127)) : mult_plan[ph]);
            if (ph == 9) quiet = 1;
            if (ph == 3) hold_req = 1;
            for (int i = 0; i < 21; i++) begin
                s = pick_sample(s);
                send_sample(s, $urandom_range(0, 11) == 0);
            end
        end

        drain();
        if (sb.n_mismatch == 0 && sb.pending() == 0)
            $display("PASS linear_interpolation_upsampler_top");
        else
            $display("FAIL linear_interpolation_upsampler_top");
        $finish;
    end

endmodule
